[rtl/fan_rpm_duty_regulator_defines.svh]
// Assertion helpers for the fan regulator.
`ifndef FAN_RPM_DUTY_REGULATOR_DEFINES_SVH
`define FAN_RPM_DUTY_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FRDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FRDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frdr_pkg.sv]
`default_nettype none
package frdr_pkg;

  // register indexes
  localparam logic [3:0] REG_FAN_ENABLE     = 4'd0;
  localparam logic [3:0] REG_CLOSED_LOOP    = 4'd1;
  localparam logic [3:0] REG_SPEED_GOAL     = 4'd2;
  localparam logic [3:0] REG_RPM_DEADBAND   = 4'd3;
  localparam logic [3:0] REG_PULSES_PER_REV = 4'd4;
  localparam logic [3:0] REG_KICK_DUTY      = 4'd5;
  localparam logic [3:0] REG_TACH_KIND      = 4'd6;
  localparam logic [3:0] REG_MANUAL_DUTY    = 4'd7;

  // channel status codes
  localparam logic [1:0] ST_STOPPED    = 2'd0;
  localparam logic [1:0] ST_CHANGING   = 2'd1;
  localparam logic [1:0] ST_LOCKED     = 2'd2;
  localparam logic [1:0] ST_FRUSTRATED = 2'd3;

  localparam int unsigned DividendW = 22;
  localparam int unsigned DivisorW  = 20;

  localparam logic [DividendW-1:0] PeriodRpmNum = 22'd3750000;
  localparam logic [DividendW-1:0] PulseRpmMul  = 22'd60;
  // x/100 as (x * ceil(2^23/100)) >> 23, exact for any 16-bit x
  localparam logic [16:0]          RpmStepRecip = 17'd83887;
  localparam int unsigned          RpmStepShift = 23;
  localparam int unsigned          MinIntervalMs = 10;
  localparam logic [10:0]          NoSampleMax   = 11'd2047;
  localparam logic [6:0]           PctMax        = 7'd100;

  typedef struct packed {
    logic        fan_enable;
    logic        closed_loop;
    logic [15:0] speed_goal;
    logic [15:0] rpm_deadband;
    logic [3:0]  pulses_per_rev;
    logic [6:0]  kick_duty;
    logic        tach_kind;
    logic [6:0]  manual_duty;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    clamp_pct = (v > PctMax) ? PctMax : v;
  endfunction

endpackage
`default_nettype wire

[rtl/frdr_cfg.sv]
`default_nettype none
module frdr_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [3:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output frdr_pkg::cfg_t     cfg_o
);
  import frdr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FAN_ENABLE:     cfg_d.fan_enable     = cfg_data_i[0];
        REG_CLOSED_LOOP:    cfg_d.closed_loop    = cfg_data_i[0];
        REG_SPEED_GOAL:     cfg_d.speed_goal     = cfg_data_i;
        REG_RPM_DEADBAND:   cfg_d.rpm_deadband   = cfg_data_i;
        REG_PULSES_PER_REV: cfg_d.pulses_per_rev = cfg_data_i[3:0];
        REG_KICK_DUTY:      cfg_d.kick_duty      = cfg_data_i[6:0];
        REG_TACH_KIND:      cfg_d.tach_kind      = cfg_data_i[0];
        REG_MANUAL_DUTY:    cfg_d.manual_duty    = cfg_data_i[6:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                <= '0;
      cfg_q.pulses_per_rev <= 4'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

[rtl/frdr_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module frdr_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire frdr_pkg::div_req_t req_i,
  output frdr_pkg::div_rsp_t  rsp_o
);
  import frdr_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW);
  localparam logic [CntW-1:0] CntLast = CntW'(DividendW - 1);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DivisorW:0] trial;
  logic [DivisorW:0] diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

[rtl/fan_rpm_duty_regulator.sv]
// Path from accept to result: fan off goes straight to the output state; no
// fresh sample runs the measure, adjust and flag steps; a fresh sample first
// waits for a full divider pass, then interval, measure, adjust and flag steps.
// One item at a time: in_stall_o stays high until the result is taken.
// Reset (async, active low) clears control and result state, not the tach
// sample or divider data; pulses_per_rev resets to 2, adjust interval to 10 ms.
`default_nettype none
`include "fan_rpm_duty_regulator_defines.svh"
module fan_rpm_duty_regulator #(
  parameter int unsigned TICK_MS           = 10,
  parameter int unsigned MAX_INTERVAL_MS   = 60,
  parameter int unsigned SAMPLE_TIMEOUT_MS = 1048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // items in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        tach_ready_i,
  input  wire logic [15:0] tach_count_i,
  // results out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       duty_pct_o,
  output logic [15:0]      rpm_now_o,
  output logic [1:0]       fan_state_o,
  output logic             stalled_o,
  output logic             adjusted_o
);
  import frdr_pkg::*;

  localparam int unsigned IvW = $clog2(MAX_INTERVAL_MS + 1);
  localparam int unsigned ElW = $clog2(MAX_INTERVAL_MS + TICK_MS + 1);
  localparam logic [IvW-1:0]       IvMax   = IvW'(MAX_INTERVAL_MS);
  localparam logic [IvW-1:0]       IvMin   = IvW'(MinIntervalMs);
  localparam logic [9:0]           QuoKnee = 10'(MAX_INTERVAL_MS - MinIntervalMs);
  localparam logic [ElW-1:0]       ElTick  = ElW'(TICK_MS);
  localparam logic [11:0]          NsTick  = 12'(TICK_MS);
  localparam logic [10:0]          NsLimit = 11'(SAMPLE_TIMEOUT_MS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_IVAL = 3'd2;
  localparam logic [2:0] S_MEAS = 3'd4;
  localparam logic [2:0] S_ADJ  = 3'd5;
  localparam logic [2:0] S_FLAG = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]     state_q, state_d;
  logic           ready_q, ready_d;
  logic [15:0]    count_q, count_d;
  logic [15:0]    meas_q, meas_d;
  logic [10:0]    nos_q, nos_d;
  logic [IvW-1:0] iv_q, iv_d;
  logic [ElW-1:0] el_q, el_d;
  logic [6:0]     duty_q, duty_d;
  logic [1:0]     status_q, status_d;
  logic           was_on_q, was_on_d;
  logic           adj_q, adj_d;
  logic           stalled_q, stalled_d;

  logic           in_acc;
  logic [3:0]     ppr;
  logic [15:0]    rpm_sat;
  logic [15:0]    abs_diff;
  logic [32:0]    step_prod;
  logic [9:0]     step_quo;
  logic [11:0]    ns_sum;
  logic [10:0]    ns_sat;
  logic [ElW-1:0] el_sum;
  logic [16:0]    act_plus_db;
  logic [16:0]    tgt_plus_db;
  logic           need_up;
  logic           need_down;
  logic [6:0]     up_base;

  frdr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  frdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ppr = (cfg.pulses_per_rev == 4'd0) ? 4'd1 : cfg.pulses_per_rev;

  assign rpm_sat = (count_q == 16'd0) ? 16'd0 :
                   (div_rsp.quotient[DividendW-1:16] != '0) ? 16'hFFFF :
                   div_rsp.quotient[15:0];

  assign abs_diff = (cfg.speed_goal >= meas_q) ? (cfg.speed_goal - meas_q)
                                               : (meas_q - cfg.speed_goal);

  // RPM error in steps of 100 by reciprocal multiply
  assign step_prod = {17'd0, abs_diff} * {16'd0, RpmStepRecip};
  assign step_quo  = step_prod[RpmStepShift +: 10];

  assign ns_sum = {1'b0, (was_on_q ? nos_q : 11'd0)} + NsTick;
  assign ns_sat = (ns_sum > {1'b0, NoSampleMax}) ? NoSampleMax : ns_sum[10:0];
  assign el_sum = el_q + ElTick;

  assign act_plus_db = {1'b0, meas_q} + {1'b0, cfg.rpm_deadband};
  assign tgt_plus_db = {1'b0, cfg.speed_goal} + {1'b0, cfg.rpm_deadband};
  assign need_up     = act_plus_db < {1'b0, cfg.speed_goal};
  assign need_down   = {1'b0, meas_q} > tgt_plus_db;
  assign up_base     = (duty_q == 7'd0) ? clamp_pct(cfg.kick_duty) : duty_q;

  // divider operands for the tach conversion
  always_comb begin
    div_req.start = in_acc && cfg.fan_enable && tach_ready_i;
    if (cfg.tach_kind) begin
      div_req.dividend = DividendW'(tach_count_i) * PulseRpmMul;
      div_req.divisor  = DivisorW'(ppr);
    end else begin
      div_req.dividend = PeriodRpmNum;
      div_req.divisor  = DivisorW'(ppr) * DivisorW'(tach_count_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    count_d   = count_q;
    meas_d    = meas_q;
    nos_d     = nos_q;
    iv_d      = iv_q;
    el_d      = el_q;
    duty_d    = duty_q;
    status_d  = status_q;
    was_on_d  = was_on_q;
    adj_d     = adj_q;
    stalled_d = stalled_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ready_d = tach_ready_i;
          count_d = tach_count_i;
          if (!cfg.fan_enable) begin
            duty_d    = 7'd0;
            meas_d    = 16'd0;
            nos_d     = 11'd0;
            status_d  = ST_STOPPED;
            was_on_d  = 1'b0;
            adj_d     = 1'b0;
            stalled_d = 1'b0;
            state_d   = S_OUT;
          end else if (tach_ready_i) begin
            state_d = S_DIV1;
          end else begin
            state_d = S_MEAS;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          meas_d  = rpm_sat;
          state_d = S_IVAL;
        end
      end
      S_IVAL: begin
        iv_d    = (step_quo > QuoKnee) ? IvMin : IvMax - IvW'(step_quo);
        state_d = S_MEAS;
      end
      S_MEAS: begin
        if (!was_on_q) begin
          status_d = ST_CHANGING;
        end
        was_on_d = 1'b1;
        if (!cfg.closed_loop) begin
          duty_d = clamp_pct(cfg.manual_duty);
        end
        if (ready_q) begin
          nos_d = 11'd0;
        end else begin
          nos_d = ns_sat;
          if (ns_sat > NsLimit) begin
            meas_d = 16'd0;
          end
        end
        if (el_sum > ElW'(iv_q)) begin
          el_d  = '0;
          adj_d = 1'b1;
        end else begin
          el_d  = el_sum;
          adj_d = 1'b0;
        end
        state_d = S_ADJ;
      end
      S_ADJ: begin
        if (adj_q) begin
          if (!cfg.closed_loop) begin
            status_d = ST_LOCKED;
          end else if (need_up) begin
            if (duty_q >= PctMax) begin
              status_d = (meas_q == 16'd0) ? ST_STOPPED : ST_FRUSTRATED;
            end else begin
              duty_d   = clamp_pct(up_base + 7'd1);
              status_d = ST_CHANGING;
            end
          end else if (need_down) begin
            if (duty_q == 7'd0) begin
              // limit at zero duty is never a stall
              status_d = ST_FRUSTRATED;
            end else begin
              duty_d   = duty_q - 7'd1;
              status_d = ST_CHANGING;
            end
          end else begin
            status_d = ST_LOCKED;
          end
        end
        state_d = S_FLAG;
      end
      S_FLAG: begin
        stalled_d = (cfg.speed_goal != 16'd0) && (duty_q != 7'd0) &&
                    (status_q == ST_STOPPED);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      meas_q    <= '0;
      nos_q     <= '0;
      iv_q      <= IvMin;
      el_q      <= '0;
      duty_q    <= '0;
      status_q  <= ST_STOPPED;
      was_on_q  <= 1'b0;
      adj_q     <= 1'b0;
      stalled_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      meas_q    <= meas_d;
      nos_q     <= nos_d;
      iv_q      <= iv_d;
      el_q      <= el_d;
      duty_q    <= duty_d;
      status_q  <= status_d;
      was_on_q  <= was_on_d;
      adj_q     <= adj_d;
      stalled_q <= stalled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ready_q <= ready_d;
    count_q <= count_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign duty_pct_o  = duty_q;
  assign rpm_now_o   = meas_q;
  assign fan_state_o = status_q;
  assign stalled_o   = stalled_q;
  assign adjusted_o  = adj_q;

  `FRDR_ASSERT_IMP(a_duty_range, out_valid_o, duty_pct_o <= PctMax, "duty above 100 percent")
  `FRDR_ASSERT_IMP(a_stall_state, out_valid_o && stalled_o, fan_state_o == ST_STOPPED,
                   "stall flagged without stopped status")
  `FRDR_ASSERT_IMP(a_div_owner, div_rsp.done, state_q == S_DIV1,
                   "divider result outside a divide step")
  `FRDR_ASSERT_IMP(a_off_quiet, out_valid_o && !cfg.fan_enable,
                   duty_pct_o == 7'd0 && rpm_now_o == 16'd0 && !adjusted_o,
                   "disabled channel reports activity")
  `FRDR_ASSERT_NXT(a_one_item, in_acc, !out_valid_o || !cfg.fan_enable,
                   "result shown too early for enabled channel")

endmodule
`default_nettype wire

[verif/fan_rpm_duty_regulator_tb.sv]
`default_nettype none
module fan_rpm_duty_regulator_tb;
  import frdr_pkg::*;

  localparam int TICK_MS           = 10;
  localparam int MAX_INTERVAL_MS   = 60;
  localparam int SAMPLE_TIMEOUT_MS = 1048;
  localparam int RPM_PER_PCT       = 40;   // toy fan: 4000 RPM at full duty
  localparam logic [3:0] REG_SPARE = 4'd15; // no register behind it

  // Mirrors the regulator state and holds the readings still owed by the block.
  class fan_regulator_mirror;
    typedef struct {
      logic [6:0]  duty;
      logic [15:0] rpm;
      logic [1:0]  state;
      logic        stalled;
      logic        adjusted;
    } reading_t;

    cfg_t        cfg;
    logic [15:0] measured_rpm;
    logic [10:0] no_sample_ms;
    logic [5:0]  interval_ms;
    logic [6:0]  elapsed_ms;
    logic [6:0]  duty_now;
    logic [1:0]  status_now;
    logic        was_on;
    reading_t    due_readings[$];
    int          faults;

    function new();
      cfg = '0;
      cfg.pulses_per_rev = 4'd2;
      measured_rpm = '0;
      no_sample_ms = '0;
      interval_ms = 6'd10;
      elapsed_ms = '0;
      duty_now = '0;
      status_now = ST_STOPPED;
      was_on = 1'b0;
      faults = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      case (idx)
        REG_FAN_ENABLE:     cfg.fan_enable = data[0];
        REG_CLOSED_LOOP:    cfg.closed_loop = data[0];
        REG_SPEED_GOAL:     cfg.speed_goal = data;
        REG_RPM_DEADBAND:   cfg.rpm_deadband = data;
        REG_PULSES_PER_REV: cfg.pulses_per_rev = data[3:0];
        REG_KICK_DUTY:      cfg.kick_duty = data[6:0];
        REG_TACH_KIND:      cfg.tach_kind = data[0];
        REG_MANUAL_DUTY:    cfg.manual_duty = data[6:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] pct_cap(logic [6:0] v);
      return (v > PctMax) ? PctMax : v;
    endfunction

    function logic [15:0] speed_from_count(logic [15:0] cnt);
      int unsigned p, c, r;
      p = (cfg.pulses_per_rev == 4'd0) ? 1 : cfg.pulses_per_rev;
      c = cnt;
      if (c == 0) return 16'd0;
      if (cfg.tach_kind == 1'b0) r = PeriodRpmNum / p / c;
      else r = (c * 120) / (2 * p);
      return (r > 32'hFFFF) ? 16'hFFFF : r[15:0];
    endfunction

    function void refresh_interval();
      int d, ms;
      d = int'(cfg.speed_goal) - int'(measured_rpm);
      if (d < 0) d = -d;
      ms = MAX_INTERVAL_MS - d / 100;
      if (ms < int'(MinIntervalMs)) ms = MinIntervalMs;
      interval_ms = ms[5:0];
    endfunction

    function void note_tick(logic rdy, logic [15:0] cnt);
      reading_t   due;
      int         quiet, elapsed, act, tgt, db;
      logic [6:0] d, nd;
      bit         at_limit;
      due.adjusted = 1'b0;
      due.stalled = 1'b0;
      at_limit = 1'b0;
      if (!cfg.fan_enable) begin
        duty_now = '0;
        measured_rpm = '0;
        no_sample_ms = '0;
        status_now = ST_STOPPED;
        was_on = 1'b0;
      end else begin
        if (!was_on) begin
          status_now = ST_CHANGING;
          no_sample_ms = '0;
          was_on = 1'b1;
        end
        if (!cfg.closed_loop) duty_now = pct_cap(cfg.manual_duty);
        if (rdy) begin
          measured_rpm = speed_from_count(cnt);
          refresh_interval();
          no_sample_ms = '0;
        end else begin
          quiet = int'(no_sample_ms) + TICK_MS;
          if (quiet > int'(NoSampleMax)) quiet = NoSampleMax;
          no_sample_ms = quiet[10:0];
          if (quiet > SAMPLE_TIMEOUT_MS) measured_rpm = '0;
        end
        elapsed = int'(elapsed_ms) + TICK_MS;
        if (elapsed > int'(interval_ms)) begin
          elapsed = 0;
          due.adjusted = 1'b1;
        end
        elapsed_ms = elapsed[6:0];
        if (due.adjusted) begin
          if (cfg.closed_loop) begin
            d = duty_now;
            act = measured_rpm;
            tgt = cfg.speed_goal;
            db = cfg.rpm_deadband;
            if (act < tgt - db) begin
              if (d >= PctMax) begin
                at_limit = 1'b1;
              end else begin
                nd = (d == 7'd0) ? pct_cap(cfg.kick_duty) : d;
                duty_now = pct_cap(nd + 7'd1);
                status_now = ST_CHANGING;
              end
            end else if (act > tgt + db) begin
              if (d == 7'd0) begin
                at_limit = 1'b1;
              end else begin
                duty_now = d - 7'd1;
                status_now = ST_CHANGING;
              end
            end else begin
              status_now = ST_LOCKED;
            end
            // pinned duty: no spin at all means a dead fan, not a weak one
            if (at_limit)
              status_now = (measured_rpm == 16'd0 && d != 7'd0) ? ST_STOPPED : ST_FRUSTRATED;
          end else begin
            status_now = ST_LOCKED;
          end
        end
        if (cfg.speed_goal != 16'd0 && duty_now != 7'd0 && status_now == ST_STOPPED)
          due.stalled = 1'b1;
      end
      due.duty = duty_now;
      due.rpm = measured_rpm;
      due.state = status_now;
      due_readings.push_back(due);
    endfunction

    function void check_reading(logic [6:0] duty, logic [15:0] rpm, logic [1:0] state,
                                logic stalled, logic adjusted);
      reading_t due;
      if (due_readings.size() == 0) begin
        $error("reading arrived with no tick pending");
        faults++;
        return;
      end
      due = due_readings.pop_front();
      if (duty !== due.duty) begin
        $error("duty_pct expected %0d actual %0d", due.duty, duty);
        faults++;
      end
      if (rpm !== due.rpm) begin
        $error("rpm_now expected %0d actual %0d", due.rpm, rpm);
        faults++;
      end
      if (state !== due.state) begin
        $error("fan_state expected %0d actual %0d", due.state, state);
        faults++;
      end
      if (stalled !== due.stalled) begin
        $error("stalled expected %0d actual %0d", due.stalled, stalled);
        faults++;
      end
      if (adjusted !== due.adjusted) begin
        $error("adjusted expected %0d actual %0d", due.adjusted, adjusted);
        faults++;
      end
    endfunction

    function int waiting();
      return due_readings.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        tach_ready_i;
  logic [15:0] tach_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [6:0]  duty_pct_o;
  logic [15:0] rpm_now_o;
  logic [1:0]  fan_state_o;
  logic        stalled_o;
  logic        adjusted_o;

  bit calm;
  fan_regulator_mirror mirror = new();

  fan_rpm_duty_regulator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tach_ready_i (tach_ready_i),
    .tach_count_i (tach_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duty_pct_o   (duty_pct_o),
    .rpm_now_o    (rpm_now_o),
    .fan_state_o  (fan_state_o),
    .stalled_o    (stalled_o),
    .adjusted_o   (adjusted_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(99) < 31);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      mirror.check_reading(duty_pct_o, rpm_now_o, fan_state_o, stalled_o, adjusted_o);
  end

  task automatic cfg_write(logic [3:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mirror.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // returns at the accepting edge with valid still high; next caller decides
  task automatic send_tick(logic rdy, logic [15:0] cnt);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i = 1'b0;
      tach_ready_i = 1'($urandom);
      tach_count_i = 16'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    tach_ready_i = rdy;
    tach_count_i = cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_tick(rdy, cnt);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (mirror.waiting() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] with_noise(logic [15:0] v, int w);
    logic [15:0] n;
    n = 16'($urandom);
    if ($urandom_range(1) == 0) return v;
    return v | (n << w);
  endfunction

  task automatic apply_config(cfg_t c);
    cfg_write(REG_FAN_ENABLE, with_noise(16'(c.fan_enable), 1));
    cfg_write(REG_CLOSED_LOOP, with_noise(16'(c.closed_loop), 1));
    cfg_write(REG_SPEED_GOAL, c.speed_goal);
    cfg_write(REG_RPM_DEADBAND, c.rpm_deadband);
    cfg_write(REG_PULSES_PER_REV, with_noise(16'(c.pulses_per_rev), 4));
    cfg_write(REG_KICK_DUTY, with_noise(16'(c.kick_duty), 7));
    cfg_write(REG_TACH_KIND, with_noise(16'(c.tach_kind), 1));
    cfg_write(REG_MANUAL_DUTY, with_noise(16'(c.manual_duty), 7));
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.fan_enable = ($urandom_range(99) < 90);
    c.closed_loop = ($urandom_range(99) < 75);
    case ($urandom_range(5))
      0: c.speed_goal = 16'd0;
      1: c.speed_goal = 16'hFFFF;
      2: c.speed_goal = 16'($urandom);
      default: c.speed_goal = 16'($urandom_range(4000, 300));
    endcase
    case ($urandom_range(5))
      0: c.rpm_deadband = 16'd0;
      1: c.rpm_deadband = 16'hFFFF;
      2: c.rpm_deadband = 16'($urandom);
      default: c.rpm_deadband = 16'($urandom_range(200));
    endcase
    if ($urandom_range(99) < 90) c.pulses_per_rev = 4'($urandom_range(8, 1));
    else c.pulses_per_rev = 4'($urandom_range(15));
    c.kick_duty = 7'($urandom_range(127));
    c.tach_kind = 1'($urandom);
    c.manual_duty = 7'($urandom_range(127));
    return c;
  endfunction

  // tach count a fan would give at the currently predicted duty
  function automatic logic [15:0] plant_count();
    int p, spin, c;
    p = (mirror.cfg.pulses_per_rev == 4'd0) ? 1 : mirror.cfg.pulses_per_rev;
    spin = mirror.duty_now * RPM_PER_PCT;
    if (spin > 0) spin = spin + $urandom_range(60) - 30;
    if (spin <= 0) return 16'd0;
    if (mirror.cfg.tach_kind == 1'b0) c = int'(PeriodRpmNum) / p / spin;
    else c = spin * p / 60;
    return (c > 65535) ? 16'hFFFF : c[15:0];
  endfunction

  task automatic run_phase(int n, int ready_pct, bit plant);
    for (int i = 0; i < n; i++) begin
      logic        rdy;
      logic [15:0] cnt;
      int          pick;
      rdy = ($urandom_range(99) < ready_pct);
      pick = $urandom_range(99);
      if (plant && pick < 85) cnt = plant_count();
      else if (pick < 95) cnt = 16'($urandom);
      else begin
        case ($urandom_range(2))
          0: cnt = 16'h0000;
          1: cnt = 16'h0001;
          default: cnt = 16'hFFFF;
        endcase
      end
      if ($urandom_range(99) < 2) drain_results();
      send_tick(rdy, cnt);
    end
  endtask

  initial begin
    #1600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_FAN_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    tach_ready_i = 1'b0;
    tach_count_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // channel off: tach ignored, everything reads zero
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
    drain_results();

    // manual mode, duty above range, zero pulses, pulse formula saturating
    cfg_write(REG_FAN_ENABLE, 16'd1);
    cfg_write(REG_CLOSED_LOOP, 16'd0);
    cfg_write(REG_MANUAL_DUTY, 16'd127);
    cfg_write(REG_TACH_KIND, 16'd1);
    cfg_write(REG_PULSES_PER_REV, 16'd0);
    cfg_write(REG_SPEED_GOAL, 16'hFFFF);
    cfg_write(REG_RPM_DEADBAND, 16'd0);
    cfg_write(REG_KICK_DUTY, 16'd127);
    cfg_write(REG_SPARE, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'h0001);
    send_tick(1'b0, 16'h5A5A);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h8000);
    drain_results();

    // rise from zero duty with startup above range, then dead fan at full duty
    cfg_write(REG_FAN_ENABLE, 16'd0);
    send_tick(1'b1, 16'h0001);
    drain_results();
    cfg_write(REG_FAN_ENABLE, 16'd1);
    cfg_write(REG_CLOSED_LOOP, 16'd1);
    cfg_write(REG_TACH_KIND, 16'd0);
    cfg_write(REG_PULSES_PER_REV, 16'd8);
    repeat (6) send_tick(1'b1, 16'h0000);
    drain_results();

    // zero duty yet too fast for a zero target
    cfg_write(REG_FAN_ENABLE, 16'd0);
    send_tick(1'b0, 16'h0000);
    drain_results();
    cfg_write(REG_FAN_ENABLE, 16'd1);
    cfg_write(REG_SPEED_GOAL, 16'd0);
    repeat (5) send_tick(1'b1, 16'h0001);

    for (int ph = 0; ph < 8; ph++) begin
      cfg_t c;
      drain_results();
      c = random_setting();
      if (ph == 0) c.fan_enable = 1'b1;
      apply_config(c);
      calm = (ph == 5);
      if (ph == 0) begin
        // one sample, then silence past the timeout and into saturation
        send_tick(1'b1, 16'($urandom));
        run_phase(214, 0, 1'b0);
      end else begin
        run_phase(46, $urandom_range(95, 30), (ph % 4) != 3);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (64) @(posedge clk_i);
    if (mirror.faults == 0 && mirror.waiting() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/frdr_pkg.sv
rtl/frdr_cfg.sv
rtl/frdr_div.sv
rtl/fan_rpm_duty_regulator.sv
verif/fan_rpm_duty_regulator_tb.sv
